/* src/skts_pkg.sv */
// shared types and constants for the sorted key table
// no dependencies
`default_nettype none

package skts_pkg;

  // table geometry
  localparam int KEY_BITS = 32;
  localparam int DEPTH    = 256;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int KEY_W    = 32;
  localparam int POS_W    = 8;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_FOUND    = 2'd0,
    STATUS_ABSENT   = 2'd1,
    STATUS_INSERTED = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_DECIDE,
    ST_SHIFT_START,
    ST_SHIFT,
    ST_WRITE_KEY,
    ST_REPLY
  } state_t;

  // request item
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             insert_if_missing;
  } req_item_t;

  // response item
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    status_t          status;
  } rsp_item_t;

endpackage

`default_nettype wire

/* src/sorted_key_table_search_insert.sv */
// Every request runs s search steps (at most floor(log2(count))+1); an insert also moves m
// entries up, one per cycle through the table's write port (up to DEPTH-1).
// Throughput: one item at a time; the next item is taken while a result waits to be read.
// Reset clears the entry count and the control state; table words are not cleared and
// are only read below the entry count.
// sorted key table with binary search and insert, uses skts_pkg
`default_nettype none

module sorted_key_table_search_insert (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  skts_pkg::req_item_t req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output skts_pkg::rsp_item_t rsp
);

  // table storage
  logic [skts_pkg::KEY_BITS-1:0] mem [skts_pkg::DEPTH];
  logic [skts_pkg::KEY_BITS-1:0] rd_data;
  logic [skts_pkg::IDX_W-1:0]    mem_ra;
  logic [skts_pkg::IDX_W-1:0]    mem_wa;
  logic [skts_pkg::KEY_BITS-1:0] mem_wd;
  logic                          mem_we;

  // sequencer registers
  skts_pkg::state_t              state, state_next;
  logic [skts_pkg::KEY_BITS-1:0] key_q, key_next;
  logic                          ins, ins_next;
  logic [skts_pkg::CNT_W-1:0]    lo, lo_next;
  logic [skts_pkg::CNT_W-1:0]    hi, hi_next;
  logic [skts_pkg::CNT_W-1:0]    mid, mid_next;
  logic [skts_pkg::CNT_W-1:0]    idx, idx_next;
  logic [skts_pkg::CNT_W-1:0]    count, count_next;
  logic                          hit, hit_next;
  skts_pkg::rsp_item_t           res, res_next;
  skts_pkg::rsp_item_t           rsp_next;
  logic                          rsp_valid_next;

  // shared arithmetic terms
  logic [skts_pkg::CNT_W-1:0]    mid_calc;
  logic [skts_pkg::CNT_W-1:0]    idx_m1;
  logic [skts_pkg::CNT_W-1:0]    idx_m2;

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign idx_m1   = idx - skts_pkg::CNT_W'(1);
  assign idx_m2   = idx - skts_pkg::CNT_W'(2);

  // table with one write port and one read port: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skts_pkg::ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_q <= key_next;
    ins   <= ins_next;
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
    idx   <= idx_next;
    hit   <= hit_next;
    res   <= res_next;
    rsp   <= rsp_next;
  end

  assign req_stall = (state != skts_pkg::ST_IDLE);

  // sequencer
  always_comb begin
    state_next     = state;
    key_next       = key_q;
    ins_next       = ins;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    idx_next       = idx;
    count_next     = count;
    hit_next       = hit;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;
    mem_we         = 1'b0;
    mem_wa         = idx[skts_pkg::IDX_W-1:0];
    mem_wd         = rd_data;
    mem_ra         = idx_m1[skts_pkg::IDX_W-1:0];

    // output slot frees when taken
    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      skts_pkg::ST_IDLE: begin
        if (req_valid) begin
          key_next   = req.key[skts_pkg::KEY_BITS-1:0];
          ins_next   = req.insert_if_missing;
          lo_next    = '0;
          hi_next    = count;
          hit_next   = 1'b0;
          state_next = skts_pkg::ST_SEARCH;
        end
      end

      // issue a read at the midpoint, or finish the search
      skts_pkg::ST_SEARCH: begin
        if (lo < hi) begin
          mid_next   = mid_calc;
          mem_ra     = mid_calc[skts_pkg::IDX_W-1:0];
          state_next = skts_pkg::ST_COMPARE;
        end else begin
          state_next = skts_pkg::ST_DECIDE;
        end
      end

      // narrow the range; remember equality whenever the upper bound moves
      skts_pkg::ST_COMPARE: begin
        if (rd_data < key_q) begin
          lo_next = mid + skts_pkg::CNT_W'(1);
        end else begin
          hi_next  = mid;
          hit_next = (rd_data == key_q);
        end
        state_next = skts_pkg::ST_SEARCH;
      end

      // lower bound is in lo
      skts_pkg::ST_DECIDE: begin
        if ((lo < count) && hit) begin
          res_next.found    = 1'b1;
          res_next.position = skts_pkg::POS_W'(lo);
          res_next.status   = skts_pkg::STATUS_FOUND;
          state_next        = skts_pkg::ST_REPLY;
        end else if (!ins) begin
          res_next.found    = 1'b0;
          res_next.position = '0;
          res_next.status   = skts_pkg::STATUS_ABSENT;
          state_next        = skts_pkg::ST_REPLY;
        end else if (count == skts_pkg::CNT_W'(skts_pkg::DEPTH)) begin
          res_next.found    = 1'b0;
          res_next.position = '0;
          res_next.status   = skts_pkg::STATUS_FULL;
          state_next        = skts_pkg::ST_REPLY;
        end else begin
          idx_next   = count;
          state_next = skts_pkg::ST_SHIFT_START;
        end
      end

      // prime the first read of the move
      skts_pkg::ST_SHIFT_START: begin
        mem_ra = idx_m1[skts_pkg::IDX_W-1:0];
        if (idx == lo) begin
          state_next = skts_pkg::ST_WRITE_KEY;
        end else begin
          state_next = skts_pkg::ST_SHIFT;
        end
      end

      // move one entry up per cycle while reading the next one down
      skts_pkg::ST_SHIFT: begin
        mem_we   = 1'b1;
        mem_wa   = idx[skts_pkg::IDX_W-1:0];
        mem_wd   = rd_data;
        mem_ra   = idx_m2[skts_pkg::IDX_W-1:0];
        idx_next = idx_m1;
        if (idx_m1 == lo) begin
          state_next = skts_pkg::ST_WRITE_KEY;
        end
      end

      // place the new key at its sorted position
      skts_pkg::ST_WRITE_KEY: begin
        mem_we            = 1'b1;
        mem_wa            = lo[skts_pkg::IDX_W-1:0];
        mem_wd            = key_q;
        count_next        = count + skts_pkg::CNT_W'(1);
        res_next.found    = 1'b0;
        res_next.position = skts_pkg::POS_W'(lo);
        res_next.status   = skts_pkg::STATUS_INSERTED;
        state_next        = skts_pkg::ST_REPLY;
      end

      // hand the result to the output register once it is free
      skts_pkg::ST_REPLY: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = skts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = skts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* tb/sorted_key_table_search_insert_tb.sv */
// testbench for sorted_key_table_search_insert: random and directed lookups and inserts
// checked against a shadow table kept in the bench; depends on skts_pkg and the block
`timescale 1ns / 1ps

module sorted_key_table_search_insert_tb;

  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int SETTLE_CYCLES   = skts_pkg::DEPTH + 32;

  logic                clk = 1'b0;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  skts_pkg::req_item_t req;
  logic                rsp_valid;
  logic                rsp_stall;
  skts_pkg::rsp_item_t rsp;

  // shadow copy of the table contents
  logic [skts_pkg::KEY_BITS-1:0] shadow_keys [skts_pkg::DEPTH];
  int                            shadow_count = 0;

  skts_pkg::rsp_item_t pending_replies [$];
  int                  errors        = 0;
  bit                  idle_on       = 1'b1;
  bit                  hold_off_req  = 1'b0;

  sorted_key_table_search_insert dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // lower-bound search, then insert at that slot when asked and absent
  function automatic skts_pkg::rsp_item_t table_lookup_insert(skts_pkg::req_item_t item);
    logic [skts_pkg::KEY_BITS-1:0] k;
    int                            lo;
    int                            hi;
    int                            mid;
    int                            i;
    skts_pkg::rsp_item_t           r;
    k = item.key[skts_pkg::KEY_BITS-1:0];
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    r.found    = 1'b0;
    r.position = '0;
    r.status   = skts_pkg::STATUS_ABSENT;
    if (lo < shadow_count && shadow_keys[lo] == k) begin
      r.found    = 1'b1;
      r.position = lo[skts_pkg::POS_W-1:0];
      r.status   = skts_pkg::STATUS_FOUND;
    end else if (item.insert_if_missing) begin
      if (shadow_count >= skts_pkg::DEPTH) begin
        r.status = skts_pkg::STATUS_FULL;
      end else begin
        for (i = shadow_count; i > lo; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[lo] = k;
        shadow_count++;
        r.position = lo[skts_pkg::POS_W-1:0];
        r.status   = skts_pkg::STATUS_INSERTED;
      end
    end
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 300);
  endfunction

  // keys biased toward stored entries, their neighbors and the extremes
  function automatic logic [skts_pkg::KEY_W-1:0] choose_key();
    int                         r;
    logic [skts_pkg::KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (shadow_count > 0 && r < 30) begin
      k = shadow_keys[$urandom_range(0, shadow_count - 1)];
    end else if (shadow_count > 0 && r < 50) begin
      k = shadow_keys[$urandom_range(0, shadow_count - 1)];
      k = $urandom_range(0, 1) ? k + skts_pkg::KEY_W'(1) : k - skts_pkg::KEY_W'(1);
    end else if (r < 60) begin
      case ($urandom_range(0, 5))
        0: k = '0;
        1: k = '1;
        2: k = skts_pkg::KEY_W'(1);
        3: k = {1'b0, {(skts_pkg::KEY_W-1){1'b1}}};
        4: k = {1'b1, {(skts_pkg::KEY_W-1){1'b0}}};
        default: k = {{(skts_pkg::KEY_W-1){1'b1}}, 1'b0};
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 200) $display("%0t: %s", $time, what);
    errors++;
  endtask

  // offer one item, hold it until taken, then record its expected result
  task automatic send_item(input logic [skts_pkg::KEY_W-1:0] k, input logic ins);
    int                  gap;
    skts_pkg::req_item_t item;
    item.key               = k;
    item.insert_if_missing = ins;
    gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_replies.push_back(table_lookup_insert(item));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_replies_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // empty table, ends of the key range, front, middle and back inserts
  task automatic test_directed();
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'h0000_0001, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFE, 1'b1);
    send_item(32'h0100_0000, 1'b1);
    send_item(32'h00FF_FFFF, 1'b1);
    send_item(32'h00FF_FFFF, 1'b0);
    send_item(32'h0100_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b1);
  endtask

  // receiver holds off while items keep coming, so the input backs up
  task automatic test_backpressure();
    int n;
    idle_on      = 1'b0;
    hold_off_req = 1'b1;
    // start offering only once the hold-off is under way
    while (hold_off_req) @(posedge clk);
    for (n = 0; n < 8; n++) send_item($urandom, 1'b1);
    idle_on = 1'b1;
  endtask

  // mixed lookups and inserts while the table grows, with a stretch of back-to-back items
  task automatic test_random_growth();
    int n;
    for (n = 0; n < 1000; n++) begin
      idle_on = !(n >= 400 && n < 500);
      send_item(choose_key(), $urandom_range(0, 2) == 0);
    end
    idle_on = 1'b1;
  endtask

  // insert until every slot is used
  task automatic test_fill_table();
    while (shadow_count < skts_pkg::DEPTH) send_item(choose_key(), 1'b1);
  endtask

  // full table: hits still found, misses with insert rejected
  task automatic test_full_table();
    int n;
    for (n = 0; n < 550; n++) send_item(choose_key(), $urandom_range(0, 4) < 3);
  endtask

  // result receiver: random stalls plus one long hold-off on request
  initial begin : receiver
    int n;
    rsp_stall <= 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_stall <= 1'b1;
        n = HOLD_OFF_CYCLES;
      end else begin
        n = idle_len();
        if (n == 0) begin
          rsp_stall <= 1'b0;
          n = $urandom_range(1, 8);
        end else begin
          rsp_stall <= 1'b1;
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    skts_pkg::rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with none expected: %p", rsp));
      end else begin
        want = pending_replies.pop_front();
        if (rsp.found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", rsp.found, want.found));
        if (rsp.position !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d", rsp.position,
                                    want.position));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
      end
    end
  end

  // test sequence
  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_replies_drained();
    test_backpressure();
    wait_replies_drained();
    test_random_growth();
    wait_replies_drained();
    test_fill_table();
    wait_replies_drained();
    test_full_table();
    wait_replies_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("sorted_key_table_search_insert: match");
    else $display("sorted_key_table_search_insert: mismatch");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #50ms;
    $display("sorted_key_table_search_insert: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
src/skts_pkg.sv
src/sorted_key_table_search_insert.sv
tb/sorted_key_table_search_insert_tb.sv
